FILE: rtl/cfd_pkg.sv
// Shared types and constants for the checksummed frame deframer.
package cfd_pkg;

  localparam int ByteW   = 8;
  localparam int MaxData = 32;
  localparam int IdxW    = (MaxData > 1) ? $clog2(MaxData) : 1;
  localparam int CntW    = $clog2(MaxData + 1);
  // two payload banks, one per descriptor queue entry
  localparam int AddrW   = IdxW + 1;
  localparam int RamDepth = 2 * (1 << IdxW);

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [AddrW-1:0] addr_t;

  localparam byte_t MaxLen      = byte_t'(MaxData);
  localparam byte_t StartRst    = byte_t'(170);
  localparam byte_t EndRst      = byte_t'(85);

  // configuration register indexes
  localparam logic RegStart = 1'b0;
  localparam logic RegEnd   = 1'b1;

  // verified frame, minus its payload bytes
  typedef struct packed {
    byte_t start_byte;
    byte_t cmd_byte;
    byte_t len_byte;
    byte_t chk_byte;
    byte_t end_byte;
  } desc_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

FILE: rtl/cfd_ram.sv
// Generic single write port, single read port RAM with registered read.
module cfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cfd_front.sv
// Frame parser: hunts the start marker, stores payload, checks and queues frames.
module cfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  cfd_pkg::byte_t      cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cfd_pkg::byte_t      in_byte_i,
  input  logic                wr_bank_i,
  output logic                push_o,
  output cfd_pkg::desc_t      desc_o,
  output logic                ram_we_o,
  output cfd_pkg::addr_t      ram_waddr_o,
  output cfd_pkg::byte_t      ram_wdata_o
);

  typedef enum logic [2:0] {
    PhHunt, PhCmd, PhLen, PhData, PhChk, PhEnd
  } phase_e;

  phase_e         phase_q;
  cfd_pkg::byte_t start_q, end_q;
  cfd_pkg::byte_t cmd_q, len_q, sum_q, chk_q;
  cfd_pkg::cnt_t  fill_q, fill_d;
  logic           take;

  assign take   = in_valid_i && !in_stall_i;
  assign fill_d = fill_q + cfd_pkg::cnt_t'(1);

  assign ram_we_o    = take && (phase_q == PhData);
  assign ram_waddr_o = {wr_bank_i, fill_q[cfd_pkg::IdxW-1:0]};
  assign ram_wdata_o = in_byte_i;

  assign push_o = take && (phase_q == PhEnd) && (in_byte_i == end_q) && (chk_q == sum_q);
  assign desc_o = '{start_byte: start_q, cmd_byte: cmd_q, len_byte: len_q,
                    chk_byte: chk_q, end_byte: in_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      start_q <= cfd_pkg::StartRst;
      end_q   <= cfd_pkg::EndRst;
      cmd_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      chk_q   <= '0;
      fill_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cfd_pkg::RegStart: start_q <= cfg_data_i;
          cfd_pkg::RegEnd:   end_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (take) begin
        case (phase_q)
          PhHunt: begin
            if (in_byte_i == start_q) phase_q <= PhCmd;
          end
          PhCmd: begin
            cmd_q   <= in_byte_i;
            sum_q   <= in_byte_i;
            phase_q <= PhLen;
          end
          PhLen: begin
            len_q  <= in_byte_i;
            fill_q <= '0;
            // overlong frame is abandoned right away
            if (in_byte_i > cfd_pkg::MaxLen) begin
              phase_q <= PhHunt;
            end else if (in_byte_i == '0) begin
              phase_q <= PhChk;
            end else begin
              phase_q <= PhData;
            end
          end
          PhData: begin
            sum_q  <= sum_q + in_byte_i;
            fill_q <= fill_d;
            if (cfd_pkg::byte_t'(fill_d) == len_q) phase_q <= PhChk;
          end
          PhChk: begin
            chk_q   <= in_byte_i;
            phase_q <= PhEnd;
          end
          PhEnd: begin
            phase_q <= PhHunt;
          end
          default: phase_q <= PhHunt;
        endcase
      end
    end
  end

endmodule

FILE: rtl/cfd_queue.sv
// Two-entry descriptor queue; entry index doubles as the payload bank.
module cfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cfd_pkg::desc_t     desc_i,
  input  logic               pop_i,
  output cfd_pkg::desc_t     head_o,
  output logic               wr_bank_o,
  output logic               rd_bank_o,
  output cfd_pkg::q_status_t status_o
);

  cfd_pkg::desc_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  assign head_o             = ent_q[rd_ptr_q];
  assign wr_bank_o          = wr_ptr_q;
  assign rd_bank_o          = rd_ptr_q;
  assign status_o.full      = cnt_q[1];
  assign status_o.not_empty = (cnt_q != '0);

endmodule

FILE: rtl/cfd_back.sv
// Frame replay: walks a queued frame and drives the output register.
module cfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfd_pkg::desc_t     head_i,
  input  logic               rd_bank_i,
  input  cfd_pkg::q_status_t status_i,
  output logic               pop_o,
  output logic               ram_re_o,
  output cfd_pkg::addr_t     ram_raddr_o,
  input  cfd_pkg::byte_t     ram_rdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cfd_pkg::byte_t     out_byte_o,
  output logic               frame_last_o
);

  typedef enum logic [2:0] {
    StIdle, StStart, StCmd, StLen, StRead, StData, StChk, StEnd
  } state_e;

  state_e         state_q;
  cfd_pkg::cnt_t  idx_q, idx_d;
  logic           out_valid_q, last_q;
  cfd_pkg::byte_t byte_q;
  logic           out_free;
  logic           load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_d    = idx_q + cfd_pkg::cnt_t'(1);
  // a new word enters the output register this cycle
  assign load     = out_free && (state_q inside {StStart, StCmd, StLen, StData, StChk, StEnd});

  assign ram_re_o    = (state_q == StRead);
  assign ram_raddr_o = {rd_bank_i, idx_q[cfd_pkg::IdxW-1:0]};
  assign pop_o       = (state_q == StEnd) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      byte_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (status_i.not_empty) state_q <= StStart;
        end
        StStart: begin
          if (out_free) begin
            byte_q      <= head_i.start_byte;
            last_q      <= 1'b0;
            state_q     <= StCmd;
          end
        end
        StCmd: begin
          if (out_free) begin
            byte_q      <= head_i.cmd_byte;
            last_q      <= 1'b0;
            state_q     <= StLen;
          end
        end
        StLen: begin
          if (out_free) begin
            byte_q      <= head_i.len_byte;
            last_q      <= 1'b0;
            idx_q       <= '0;
            state_q     <= (head_i.len_byte == '0) ? StChk : StRead;
          end
        end
        StRead: begin
          state_q <= StData;
        end
        StData: begin
          // read data holds until the next read, so a stall just waits here
          if (out_free) begin
            byte_q      <= ram_rdata_i;
            last_q      <= 1'b0;
            idx_q       <= idx_d;
            state_q     <= (cfd_pkg::byte_t'(idx_d) == head_i.len_byte) ? StChk : StRead;
          end
        end
        StChk: begin
          if (out_free) begin
            byte_q      <= head_i.chk_byte;
            last_q      <= 1'b0;
            state_q     <= StEnd;
          end
        end
        StEnd: begin
          if (out_free) begin
            byte_q      <= head_i.end_byte;
            last_q      <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign frame_last_o = last_q;

endmodule

FILE: rtl/checksummed_frame_deframer.sv
// Top level of the checksummed frame deframer.
// Input channel: one received byte per word on in_byte_i, taken when in_valid_i
// is high and in_stall_o low. The parser hunts the start marker, then reads
// command, length, payload, checksum and end byte, one byte per unstalled cycle.
// Frames with a length above the payload limit, a bad checksum or a wrong end
// byte are dropped without any output.
// Output channel: a verified frame is replayed from its start marker on, one
// byte per word on out_byte_o, with frame_last_o set on the end byte.
// When the replay is idle, a taken end byte passes the queue count, the replay
// state and the output register before the frame's start byte appears. Header
// and trailer bytes go straight to the output register; each payload byte takes
// a payload RAM read, then the output register; the replay idles between frames.
// Two payload banks and a two-entry frame queue let parsing run on while the
// previous frame replays; in_stall_o is high only while both banks hold
// frames waiting for or under replay.
// A stalled output word holds; parsing continues until the queue fills.
// Reset empties the queue, returns the parser to hunting and sets the markers
// to 0xAA (start) and 0x55 (end). Marker writes go through cfg_we_i.
module checksummed_frame_deframer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  cfd_pkg::byte_t cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cfd_pkg::byte_t in_byte_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cfd_pkg::byte_t out_byte_o,
  output logic           frame_last_o
);

  logic               push, pop, wr_bank, rd_bank;
  cfd_pkg::desc_t     desc, head;
  cfd_pkg::q_status_t status;
  logic               ram_we, ram_re;
  cfd_pkg::addr_t     ram_waddr, ram_raddr;
  cfd_pkg::byte_t     ram_wdata, ram_rdata;

  assign in_stall_o = status.full;

  cfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (status.full),
    .in_byte_i   (in_byte_i),
    .wr_bank_i   (wr_bank),
    .push_o      (push),
    .desc_o      (desc),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  cfd_ram #(
    .Width (cfd_pkg::ByteW),
    .Depth (cfd_pkg::RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cfd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .desc_i    (desc),
    .pop_i     (pop),
    .head_o    (head),
    .wr_bank_o (wr_bank),
    .rd_bank_o (rd_bank),
    .status_o  (status)
  );

  cfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .rd_bank_i    (rd_bank),
    .status_i     (status),
    .pop_o        (pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

FILE: rtl/cfd_checker.sv
// Port-level checks for the checksummed frame deframer, bound to the top level.
module cfd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input cfd_pkg::byte_t out_byte_o,
  input logic           frame_last_o
);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(frame_last_o))
    else $error("stalled output word changed");

  // a frame is at least five words, so two end words never follow each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_last_o |=> !(out_valid_o && frame_last_o))
    else $error("end word directly after end word");

  // input stall only rises after a word was taken (a frame got queued)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a taken word");

  // output valid only drops after the receiver took the word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output word withdrawn while stalled");

endmodule

bind checksummed_frame_deframer cfd_checker u_cfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .frame_last_o (frame_last_o)
);

FILE: tb/tb.sv
// Self-checking testbench for checksummed_frame_deframer: random frames, bursts and stalls.
`timescale 1ns / 1ps

module tb;
  import cfd_pkg::*;

  localparam int Limit        = 100000;
  localparam int HoldCycles   = 600;
  localparam int SettleCycles = 12;

  typedef enum logic [2:0] {PhHunt, PhCmd, PhLen, PhData, PhChk, PhEnd} parse_ph_e;

  typedef struct packed {
    byte_t data;
    logic  last;
  } frame_word_t;

  logic  clk_i = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we = 1'b0;
  logic  cfg_idx = RegStart;
  byte_t cfg_data = '0;
  logic  in_valid = 1'b0;
  byte_t in_byte = '0;
  logic  out_stall = 1'b0;
  logic  in_stall;
  logic  out_valid;
  byte_t out_byte;
  logic  frame_last;

  // parser state mirrored by the predictor
  byte_t     start_m = StartRst;
  byte_t     end_m = EndRst;
  parse_ph_e ph = PhHunt;
  byte_t     cmd_q = '0;
  byte_t     len_q = '0;
  byte_t     sum_q = '0;
  byte_t     chk_q = '0;
  int unsigned fill_q = 0;
  byte_t     pay_q [MaxData];

  frame_word_t replay_q [$];
  byte_t       rx_stream [$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_pct = 0;
  int pat_cnt = 0;
  logic pressure_go = 1'b0;
  logic hold_on = 1'b0;

  checksummed_frame_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .frame_last_o(frame_last)
  );

  always #5 clk_i = ~clk_i;

  function automatic void emit_word(input byte_t b, input logic last);
    frame_word_t w;
    w.data = b;
    w.last = last;
    replay_q.push_back(w);
  endfunction

  // advance the parser by one received byte, queue the replay of a verified frame
  function automatic void deframe_byte(input byte_t b);
    int i;
    case (ph)
      PhHunt: if (b == start_m) ph = PhCmd;
      PhCmd: begin
        cmd_q = b;
        sum_q = b;
        ph = PhLen;
      end
      PhLen: begin
        len_q = b;
        fill_q = 0;
        if (b > MaxLen) ph = PhHunt;
        else if (b == 8'd0) ph = PhChk;
        else ph = PhData;
      end
      PhData: begin
        pay_q[fill_q] = b;
        sum_q = sum_q + b;
        fill_q++;
        if (fill_q >= len_q) ph = PhChk;
      end
      PhChk: begin
        chk_q = b;
        ph = PhEnd;
      end
      default: begin
        ph = PhHunt;
        if (b == end_m && chk_q == sum_q) begin
          emit_word(start_m, 1'b0);
          emit_word(cmd_q, 1'b0);
          emit_word(len_q, 1'b0);
          for (i = 0; i < len_q; i++) emit_word(pay_q[i], 1'b0);
          emit_word(chk_q, 1'b0);
          emit_word(b, 1'b1);
        end
      end
    endcase
  endfunction

  // queue one frame with random payload; corrupt checksum or end byte on request
  function automatic void push_frame(input byte_t cmd, input int len, input logic bad_chk,
                                     input logic bad_end);
    byte_t sum;
    byte_t d;
    int i;
    sum = cmd;
    rx_stream.push_back(start_m);
    rx_stream.push_back(cmd);
    rx_stream.push_back(byte_t'(len));
    for (i = 0; i < len; i++) begin
      d = byte_t'($urandom_range(0, 255));
      sum = sum + d;
      rx_stream.push_back(d);
    end
    if (bad_chk) sum = sum ^ byte_t'($urandom_range(1, 255));
    rx_stream.push_back(sum);
    rx_stream.push_back(bad_end ? end_m ^ byte_t'($urandom_range(1, 255)) : end_m);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 6);
    else if (r < 92) return $urandom_range(7, MaxData - 1);
    else return MaxData;
  endfunction

  // mostly well-formed frames, the rest broken frames and line noise
  function automatic void fill_random(input int n);
    int cnt;
    int r;
    int len;
    int k;
    int i;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      k = rx_stream.size();
      if (r < 60) begin
        push_frame(byte_t'($urandom_range(0, 255)), pick_len(), 1'b0, 1'b0);
      end else if (r < 68) begin
        push_frame(byte_t'($urandom_range(0, 255)), pick_len(), 1'b1, 1'b0);
      end else if (r < 74) begin
        push_frame(byte_t'($urandom_range(0, 255)), pick_len(), 1'b0, 1'b1);
      end else if (r < 80) begin
        rx_stream.push_back(start_m);
        rx_stream.push_back(byte_t'($urandom_range(0, 255)));
        rx_stream.push_back(byte_t'($urandom_range(MaxData + 1, 255)));
      end else if (r < 88) begin
        // truncated frame: following bytes land in its payload
        len = $urandom_range(2, 8);
        rx_stream.push_back(start_m);
        rx_stream.push_back(byte_t'($urandom_range(0, 255)));
        rx_stream.push_back(byte_t'(len));
        for (i = 0; i < $urandom_range(0, len - 1); i++)
          rx_stream.push_back(byte_t'($urandom_range(0, 255)));
      end else begin
        for (i = 0; i < $urandom_range(1, 4); i++)
          rx_stream.push_back(byte_t'($urandom_range(0, 255)));
      end
      cnt += rx_stream.size() - k;
    end
  endfunction

  task automatic write_regs(input byte_t s, input byte_t e);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= RegStart;
    cfg_data <= s;
    start_m = s;
    @(posedge clk_i);
    cfg_idx <= RegEnd;
    cfg_data <= e;
    end_m = e;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (rx_stream.size() != 0 || in_valid || replay_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin : drv_p
    logic  nv;
    byte_t nb;
    nv = in_valid;
    nb = in_byte;
    if (in_valid && !in_stall) begin
      deframe_byte(in_byte);
      nv = 1'b0;
    end
    if (!nv && rst_n) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (rx_stream.size() != 0) begin
        nv = 1'b1;
        nb = rx_stream.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid <= nv;
    in_byte <= nb;
  end

  // receiver: checks each word, stalls on a changing duty cycle
  always @(posedge clk_i) begin : mon_p
    frame_word_t w;
    if (out_valid && !out_stall) begin
      if (replay_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: byte %h last %b", out_byte, frame_last);
      end else begin
        w = replay_q.pop_front();
        if (out_byte !== w.data || frame_last !== w.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     w.data, w.last, out_byte, frame_last);
        end
      end
    end
    if (pat_cnt == 0) begin
      pat_cnt = 64;
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
    end else begin
      pat_cnt--;
    end
    out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // long receiver hold-off so both payload banks fill and the input stalls
  initial begin : holdoff_p
    wait (pressure_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin : watchdog_p
    cycles++;
    if (cycles > Limit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stim_p
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    write_regs(StartRst, EndRst);

    // directed: byte extremes, zero length, overlong, marker as command, bad frames
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    push_frame(8'hFF, 0, 1'b0, 1'b0);
    rx_stream.push_back(start_m);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(MaxLen + 8'd1);
    push_frame(start_m, 0, 1'b0, 1'b0);
    push_frame(8'h3C, 0, 1'b1, 1'b0);
    push_frame(8'hC3, 1, 1'b0, 1'b1);
    fill_random(60);
    drain();

    write_regs(8'h00, 8'hFF);
    fill_random(50);
    drain();

    write_regs(8'hFF, 8'h00);
    pressure_go = 1'b1;
    fill_random(60);
    drain();

    write_regs(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
    fill_random(55);
    drain();

    write_regs(8'h7E, 8'h7E);
    fill_random(55);
    drain();

    errors += replay_q.size();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cfd_pkg.sv
rtl/cfd_ram.sv
rtl/cfd_front.sv
rtl/cfd_queue.sv
rtl/cfd_back.sv
rtl/checksummed_frame_deframer.sv
rtl/cfd_checker.sv
tb/tb.sv
